// ----- sv/utf8sd_pkg.sv -----
// utf8sd_pkg: shared types and constants of the byte-serial utf-8 decoder
// used by utf8sd_step, utf8_stream_decoder_top and its checker

package utf8sd_pkg;

  // character count limit, taken down to the 16-bit count field
  localparam longint unsigned MAX_TEXT_CHARS = 65535;
  localparam int CountW = 16;
  localparam logic [CountW-1:0] CountLimit =
    (MAX_TEXT_CHARS > 65535) ? 16'hFFFF : CountW'(MAX_TEXT_CHARS);

  localparam int CpW      = 31;
  localparam int PendW    = 3;
  localparam int OutDataW = 48;

  // lead byte class bounds
  localparam logic [7:0] Lead2Min = 8'h80;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead4Min = 8'hF0;
  localparam logic [7:0] Lead5Min = 8'hF8;
  localparam logic [7:0] Lead6Min = 8'hFC;

  // payload masks
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;
  localparam logic [7:0] Lead5Mask = 8'h03;
  localparam logic [7:0] Lead6Mask = 8'h01;

  // decoder state between bytes
  typedef struct packed {
    logic [PendW-1:0]  pending;
    logic [CpW-1:0]    partial;
    logic [CountW-1:0] count;
  } state_t;

  // one decoded character
  typedef struct packed {
    logic [CountW-1:0] char_count;
    logic              last_char;
    logic [CpW-1:0]    code_point;
  } result_t;

endpackage

// ----- sv/utf8sd_step.sv -----
// utf8sd_step: combinational decode of one text byte against the current state
// depends on utf8sd_pkg

module utf8sd_step (
  input  utf8sd_pkg::state_t  st,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  output utf8sd_pkg::state_t  st_next,
  output logic                res_valid,
  output utf8sd_pkg::result_t res
);
  import utf8sd_pkg::*;

  logic [PendW-1:0]  pend_n;
  logic [CpW-1:0]    part_n;
  logic [CpW-1:0]    cp;
  logic [CountW-1:0] cnt_n;

  // lead byte opens a sequence, otherwise append six payload bits
  always_comb begin
    if (st.pending == '0) begin
      if (text_byte < Lead2Min) begin
        part_n = CpW'(text_byte);
        pend_n = PendW'(0);
      end else if (text_byte < Lead3Min) begin
        part_n = CpW'(text_byte & Lead2Mask);
        pend_n = PendW'(1);
      end else if (text_byte < Lead4Min) begin
        part_n = CpW'(text_byte & Lead3Mask);
        pend_n = PendW'(2);
      end else if (text_byte < Lead5Min) begin
        part_n = CpW'(text_byte & Lead4Mask);
        pend_n = PendW'(3);
      end else if (text_byte < Lead6Min) begin
        part_n = CpW'(text_byte & Lead5Mask);
        pend_n = PendW'(4);
      end else begin
        part_n = CpW'(text_byte & Lead6Mask);
        pend_n = PendW'(5);
      end
    end else begin
      part_n = {st.partial[CpW-7:0], text_byte[5:0]};
      pend_n = st.pending - PendW'(1);
    end
  end

  // missing bytes on early end of text count as zero
  always_comb begin
    case (pend_n)
      3'd0:    cp = part_n;
      3'd1:    cp = {part_n[CpW-7:0], 6'd0};
      3'd2:    cp = {part_n[CpW-13:0], 12'd0};
      3'd3:    cp = {part_n[CpW-19:0], 18'd0};
      3'd4:    cp = {part_n[CpW-25:0], 24'd0};
      3'd5:    cp = {part_n[CpW-31:0], 30'd0};
      default: cp = '0;
    endcase
  end

  // saturating character count
  assign cnt_n = (st.count < CountLimit) ? st.count + CountW'(1) : CountLimit;

  assign res_valid      = (pend_n == '0) || end_of_text;
  assign res.code_point = cp;
  assign res.last_char  = end_of_text;
  assign res.char_count = cnt_n;

  // state after this byte
  always_comb begin
    if (res_valid) begin
      st_next.pending = '0;
      st_next.partial = '0;
      st_next.count   = end_of_text ? '0 : cnt_n;
    end else begin
      st_next.pending = pend_n;
      st_next.partial = part_n;
      st_next.count   = st.count;
    end
  end

endmodule

// ----- sv/utf8_stream_decoder_top.sv -----
// utf8_stream_decoder_top: byte-serial utf-8 decoder with a registered,
// skid-buffered output stream; depends on utf8sd_pkg and utf8sd_step
//
// usage:
//   slave side takes one text byte per beat: s_tdata = text byte,
//   s_tlast = end of text (final byte of the string).
//   master side gives one beat per completed character:
//   m_tdata[30:0] = code point, m_tdata[46:31] = character count of the
//   string so far (saturating at 65535), m_tdata[47] = 0, m_tlast = last
//   character of the string.
//   lead bytes follow the legacy one- to six-byte classes; continuation
//   bytes are not checked. an end of text inside a sequence pads the
//   missing bytes with zeros and emits the character.
//   a character beat is registered once the byte that completes it is accepted,
//   into the output register, or into the skid register while the output is
//   stalled. throughput: one byte per cycle while s_tready is high.
//   when the receiver stalls, one more character is held in a skid
//   register; s_tready drops only while that register is full.
//   reset (rst, synchronous) empties both output registers and clears the
//   pending count, partial value and character count.

module utf8_stream_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] text_byte
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [utf8sd_pkg::OutDataW-1:0] m_tdata, // [30:0] code_point, [46:31] char_count
  output logic                          m_tlast
);
  import utf8sd_pkg::*;

  state_t  st;
  state_t  st_next;
  logic    res_valid;
  result_t res;
  logic    acc_in;
  logic    fire;
  logic    out_free;
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  utf8sd_step u_step (
    .st          (st),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .st_next     (st_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign s_tready = !skid_valid;
  assign acc_in   = s_tvalid && s_tready;
  assign fire     = acc_in && res_valid;
  assign out_free = !out_valid || m_tready;

  // decoder state and output valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (acc_in) begin
        st <= st_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= fire;
        end else begin
          out_valid <= fire;
        end
      end else if (fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (fire) begin
          skid_res <= res;
        end
      end else if (fire) begin
        out_res <= res;
      end
    end else if (fire) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.char_count, out_res.code_point};
  assign m_tlast  = out_res.last_char;

endmodule

// ----- sv/utf8sd_checker.sv -----
// utf8sd_checker: port-level assertions for utf8_stream_decoder_top
// depends on utf8sd_pkg; bound to the top level below

module utf8sd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [utf8sd_pkg::OutDataW-1:0] m_tdata,
  input logic                            m_tlast
);
  import utf8sd_pkg::*;

  // stalled output beat stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  // stalled output beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  // every character beat counts at least itself
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OutDataW-2:CpW] != '0)
    else $error("character count is zero on an output beat");

  // reset empties the output side and opens the input
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_utf8sd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- tb/utf8_stream_decoder_checker.sv -----
// utf8_stream_decoder_checker: watches both stream channels of the decoder,
// predicts each character beat from the accepted text bytes and compares.
// depends on utf8sd_pkg for widths, lead class bounds, masks and result_t

module utf8_stream_decoder_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] text_byte
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [utf8sd_pkg::OutDataW-1:0] m_tdata,   // [30:0] code_point, [46:31] char_count
  input  logic                            m_tlast,
  output int unsigned                     mismatches,
  output int unsigned                     waiting,
  output int unsigned                     chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import utf8sd_pkg::*;

  // predicted decoder state
  logic [PendW-1:0]  cont_left;
  logic [CpW-1:0]    gathered;
  logic [CountW-1:0] string_chars;
  result_t           expected_chars[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] char beat %0d: %s", $time, chars_checked, msg);
    mismatches++;
  endtask

  // advance the predicted state by one text byte, queue a character if done
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    result_t ch;
    if (cont_left == '0) begin
      if (b < Lead2Min) begin
        gathered  = CpW'(b);
        cont_left = PendW'(0);
      end else if (b < Lead3Min) begin
        gathered  = CpW'(b & Lead2Mask);
        cont_left = PendW'(1);
      end else if (b < Lead4Min) begin
        gathered  = CpW'(b & Lead3Mask);
        cont_left = PendW'(2);
      end else if (b < Lead5Min) begin
        gathered  = CpW'(b & Lead4Mask);
        cont_left = PendW'(3);
      end else if (b < Lead6Min) begin
        gathered  = CpW'(b & Lead5Mask);
        cont_left = PendW'(4);
      end else begin
        gathered  = CpW'(b & Lead6Mask);
        cont_left = PendW'(5);
      end
    end else begin
      // continuation: top bits ignored, value kept to 31 bits
      gathered  = {gathered[CpW-7:0], b[5:0]};
      cont_left = cont_left - 1'b1;
    end
    if (cont_left != '0 && !eot) return;
    // bytes cut off by the end of text count as zero
    ch.code_point = gathered << (6 * cont_left);
    if (string_chars < CountLimit) string_chars = string_chars + 1'b1;
    ch.char_count = string_chars;
    ch.last_char  = eot;
    expected_chars.push_back(ch);
    cont_left = '0;
    gathered  = '0;
    if (eot) string_chars = '0;
  endtask

  // output beats are compared before the byte of this edge is predicted
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      cont_left    = '0;
      gathered     = '0;
      string_chars = '0;
      expected_chars.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("beat with no character due, code_point 0x%0h",
                                    m_tdata[CpW-1:0]));
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata[CpW-1:0] !== want.code_point)
            report_mismatch($sformatf("code_point 0x%0h, expected 0x%0h",
                                      m_tdata[CpW-1:0], want.code_point));
          if (m_tlast !== want.last_char)
            report_mismatch($sformatf("last_char %0b, expected %0b",
                                      m_tlast, want.last_char));
          if (m_tdata[CpW+CountW-1:CpW] !== want.char_count)
            report_mismatch($sformatf("char_count %0d, expected %0d",
                                      m_tdata[CpW+CountW-1:CpW], want.char_count));
        end
        chars_checked++;
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
    end
    waiting <= expected_chars.size();
  end

endmodule

// ----- tb/utf8_stream_decoder_top_test.sv -----
// utf8_stream_decoder_top_test: drives text bytes into utf8_stream_decoder_top
// with random gaps and stalls; utf8_stream_decoder_checker judges the beats
// depends on utf8sd_pkg, utf8_stream_decoder_top and utf8_stream_decoder_checker

module utf8_stream_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import utf8sd_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomBytes = 420;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = '0;   // [7:0] text_byte
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;         // [30:0] code_point, [46:31] char_count
  logic                m_tlast;

  int unsigned mismatches;
  int unsigned waiting;
  int unsigned chars_checked;
  int unsigned bytes_sent   = 0;
  int unsigned cycle_count  = 0;
  bit          sender_idles   = 1'b0;
  bit          receiver_idles = 1'b0;

  // directed text, {end_of_text, byte}
  logic [8:0] directed_seq[$] = {
    9'h000,                                        // zero byte
    9'h0C2, 9'h0A9,                                // two-byte char
    9'h0BF, 9'h03F,                                // stray continuation as lead
    9'h0E2, 9'h082, 9'h0AC,                        // three-byte char
    9'h0F0, 9'h09F, 9'h098, 9'h080,                // four-byte char
    9'h0FB, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,        // largest five-byte char
    9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, // largest six-byte char
    9'h0F4, 9'h190,                                // end of text mid sequence
    9'h1FC,                                        // end of text on a lead
    9'h17F                                         // one-byte char ending text
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  utf8_stream_decoder_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  utf8_stream_decoder_checker decode_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .waiting       (waiting),
    .chars_checked (chars_checked)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters still due", cycle_count, waiting);
      $display("utf8_stream_decoder_top_test: FAIL");
      $finish;
    end
  end

  // one text byte beat, after an optional gap
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // well-formed lead class with mostly proper continuations, rare early end
  task automatic send_random_char();
    int unsigned len;
    logic [7:0]  lead;
    logic [7:0]  b;
    logic        eot;
    len = $urandom_range(1, 6);
    case (len)
      1: lead = 8'($urandom_range(0, Lead2Min - 1));
      2: lead = 8'($urandom_range(Lead2Min, Lead3Min - 1));
      3: lead = 8'($urandom_range(Lead3Min, Lead4Min - 1));
      4: lead = 8'($urandom_range(Lead4Min, Lead5Min - 1));
      5: lead = 8'($urandom_range(Lead5Min, Lead6Min - 1));
      default: lead = 8'($urandom_range(Lead6Min, 8'hFF));
    endcase
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = lead;
      else if ($urandom_range(0, 9) != 0) b = {2'b10, 6'($urandom_range(0, 63))};
      else b = 8'($urandom_range(0, 255));
      if (i == len - 1) eot = ($urandom_range(0, 7) == 0);
      else eot = ($urandom_range(0, 29) == 0);
      send_byte(b, eot);
      if (eot) break;
    end
  endtask

  // mostly whole characters, some loose random bytes
  task automatic send_random_text(input int unsigned nbytes);
    int unsigned stop_at;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      else send_random_char();
    end
  endtask

  // hold the sender until every predicted character has come out
  task automatic drain_decoder();
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // receiver: random stalls per beat while enabled
  initial begin : sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed text with idling on both sides
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);
    s_tvalid <= 1'b0;
    drain_decoder();

    // random text: full idling, then back to back, then receiver stalls only
    send_random_text(RandomBytes * 4 / 9);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    send_random_text(RandomBytes * 2 / 9);
    receiver_idles = 1'b1;
    send_random_text(RandomBytes / 3);
    send_byte(8'h41, 1'b1);
    s_tvalid <= 1'b0;
    drain_decoder();
    repeat (4) @(posedge clk);

    $display("sent %0d text bytes of all lead classes, early ends and loose bytes;",
             bytes_sent);
    $display("checked %0d character beats under gaps, back to back runs and stalls",
             chars_checked);
    if (mismatches == 0) begin
      $display("utf8_stream_decoder_top_test: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("utf8_stream_decoder_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/utf8sd_pkg.sv
sv/utf8sd_step.sv
sv/utf8_stream_decoder_top.sv
sv/utf8sd_checker.sv
tb/utf8_stream_decoder_checker.sv
tb/utf8_stream_decoder_top_test.sv
